// ===== rtl/jt_pkg.sv =====
package jt_pkg;

    localparam int KEY_W    = 22;
    localparam int STATUS_W = 16;
    localparam int OUT_ID_W = 5;
    localparam int OUT_CNT_W = 5;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_FIND = 2'd1,
        OP_MARK = 2'd2,
        OP_REAP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_FULL    = 2'd1,
        ERR_MISSING = 2'd2
    } t_err;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic                done;
        logic [STATUS_W-1:0] status;
    } t_payload;

    typedef struct packed {
        logic shift;
        logic put;
    } t_ring_ctl;

endpackage

// ===== rtl/jt_cell.sv =====
module jt_cell import jt_pkg::*; #(
    parameter int IW  = 5,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  t_ring_ctl     i_ctl,
    input  logic [IW-1:0] i_len,
    input  logic [IW-1:0] i_put_idx,
    input  logic [IW-1:0] i_put_id,
    input  t_payload      i_put_pay,
    input  logic [IW-1:0] i_nbr_id,
    input  t_payload      i_nbr_pay,
    output logic [IW-1:0] o_id,
    output t_payload      o_pay
);

    localparam logic [IW-1:0] IDX_W  = IW'(IDX);
    localparam logic [IW-1:0] NEXT_W = IW'(IDX + 1);

    logic [IW-1:0] r_id;
    t_payload      r_pay;

    always_ff @(posedge i_clk) begin
        if (i_ctl.put && (i_put_idx == IDX_W)) begin
            r_id  <= i_put_id;
            r_pay <= i_put_pay;
        end else if (i_ctl.shift && (NEXT_W < i_len)) begin
            r_id  <= i_nbr_id;
            r_pay <= i_nbr_pay;
        end
    end

    assign o_id  = r_id;
    assign o_pay = r_pay;

endmodule

// ===== rtl/jt_ctrl.sv =====
module jt_ctrl import jt_pkg::*; #(
    parameter int ENTRIES = 16,
    parameter int IW      = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_op,
    input  logic [KEY_W-1:0]     i_group_key,
    input  logic [STATUS_W-1:0]  i_exit_status_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_ok,
    output logic [1:0]           o_error_code,
    output logic [OUT_ID_W-1:0]  o_job_id,
    output logic                 o_is_done,
    output logic [STATUS_W-1:0]  o_exit_status_out,
    output logic [OUT_CNT_W-1:0] o_entry_count,
    output t_ring_ctl            o_ctl,
    output logic [IW-1:0]        o_len,
    output logic [IW-1:0]        o_put_idx,
    output logic [IW-1:0]        o_put_id,
    output t_payload             o_put_pay,
    input  logic [IW-1:0]        i_head_id,
    input  t_payload             i_head_pay
);

    localparam logic [IW-1:0] FULL = IW'(ENTRIES);
    localparam logic [IW-1:0] ONE  = IW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_POST,
        S_SCAN,
        S_APPEND,
        S_DONE
    } t_state;

    t_state              r_state;
    t_op                 r_op;
    logic [KEY_W-1:0]    r_key;
    logic [STATUS_W-1:0] r_st;
    logic [IW-1:0]       r_count;
    logic [IW-1:0]       r_left;
    logic [IW-1:0]       r_cand;
    logic [ENTRIES:0]    r_used;
    logic                r_found;
    logic                r_ok;
    t_err                r_err;
    logic [IW-1:0]       r_id;
    logic                r_done;
    logic [STATUS_W-1:0] r_stat;

    logic                 r_out_valid;
    logic                 r_o_ok;
    logic [1:0]           r_o_err;
    logic [OUT_ID_W-1:0]  r_o_id;
    logic                 r_o_done;
    logic [STATUS_W-1:0]  r_o_stat;
    logic [OUT_CNT_W-1:0] r_o_cnt;

    logic match;

    assign match = (i_head_pay.key == r_key) && !r_found;

    always_comb begin
        o_ctl     = '0;
        o_put_idx = r_count - ONE;
        o_put_id  = i_head_id;
        o_put_pay = i_head_pay;
        unique case (r_state)
            S_PASS: begin
                o_ctl.shift = 1'b1;
                if (r_op == OP_REAP) begin
                    o_ctl.put = !i_head_pay.done;
                end else begin
                    o_ctl.put = 1'b1;
                    if (r_op == OP_MARK && match) begin
                        o_put_pay.done   = 1'b1;
                        o_put_pay.status = r_st;
                    end
                end
            end
            S_APPEND: begin
                o_ctl.put        = 1'b1;
                o_put_idx        = r_count;
                o_put_id         = r_id;
                o_put_pay.key    = r_key;
                o_put_pay.done   = 1'b0;
                o_put_pay.status = '0;
            end
            default: begin
            end
        endcase
    end

    assign o_len      = r_count;
    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= t_op'(i_op);
                        r_key   <= i_group_key;
                        r_st    <= i_exit_status_in;
                        r_found <= 1'b0;
                        r_ok    <= 1'b0;
                        r_err   <= ERR_NONE;
                        r_id    <= '0;
                        r_done  <= 1'b0;
                        r_stat  <= '0;
                        r_used  <= '0;
                        r_cand  <= ONE;
                        r_left  <= r_count;
                        if (t_op'(i_op) == OP_ADD && r_count == FULL) begin
                            r_err   <= ERR_FULL;
                            r_state <= S_DONE;
                        end else if (r_count == '0) begin
                            r_state <= S_POST;
                        end else begin
                            r_state <= S_PASS;
                        end
                    end
                end
                S_PASS: begin
                    r_left <= r_left - ONE;
                    unique case (r_op)
                        OP_ADD: begin
                            r_used[i_head_id] <= 1'b1;
                        end
                        OP_FIND, OP_MARK: begin
                            if (match) begin
                                r_found <= 1'b1;
                                r_id    <= i_head_id;
                                if (r_op == OP_FIND) begin
                                    r_done <= i_head_pay.done;
                                    r_stat <= i_head_pay.status;
                                end
                            end
                        end
                        OP_REAP: begin
                            if (i_head_pay.done) begin
                                r_count <= r_count - ONE;
                            end
                        end
                    endcase
                    if (r_left == ONE) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    unique case (r_op)
                        OP_ADD: begin
                            r_state <= S_SCAN;
                        end
                        OP_FIND, OP_MARK: begin
                            if (r_found) begin
                                r_ok <= 1'b1;
                            end else begin
                                r_err <= ERR_MISSING;
                            end
                            r_state <= S_DONE;
                        end
                        OP_REAP: begin
                            r_ok    <= 1'b1;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_SCAN: begin
                    if (!r_used[r_cand]) begin
                        r_id    <= r_cand;
                        r_state <= S_APPEND;
                    end else begin
                        r_cand <= r_cand + ONE;
                    end
                end
                S_APPEND: begin
                    r_count <= r_count + ONE;
                    r_ok    <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_ok      <= r_ok;
                        r_o_err     <= r_err;
                        r_o_id      <= OUT_ID_W'(r_id);
                        r_o_done    <= r_done;
                        r_o_stat    <= r_stat;
                        r_o_cnt     <= OUT_CNT_W'(r_count);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_ok              = r_o_ok;
    assign o_error_code      = r_o_err;
    assign o_job_id          = r_o_id;
    assign o_is_done         = r_o_done;
    assign o_exit_status_out = r_o_stat;
    assign o_entry_count     = r_o_cnt;

endmodule

// ===== rtl/job_table_with_lowest_free_id_unit.sv =====
// Flow: find, mark done and reap rotate the table once through the cell chain, then
// register the result. Add does one rotation plus a scan of the used-id map, then
// appends the new entry; add on a full table registers a full error without a rotation.
// Throughput: one transaction at a time; the next is accepted once the result is registered.
// Reset (synchronous, active low) empties the table; entry contents are not cleared.
module job_table_with_lowest_free_id_unit import jt_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_op,
    input  logic [KEY_W-1:0]     i_group_key,
    input  logic [STATUS_W-1:0]  i_exit_status_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_ok,
    output logic [1:0]           o_error_code,
    output logic [OUT_ID_W-1:0]  o_job_id,
    output logic                 o_is_done,
    output logic [STATUS_W-1:0]  o_exit_status_out,
    output logic [OUT_CNT_W-1:0] o_entry_count
);

    localparam int IW = $clog2(ENTRIES + 1);

    t_ring_ctl     ctl;
    logic [IW-1:0] len;
    logic [IW-1:0] put_idx;
    logic [IW-1:0] put_id;
    t_payload      put_pay;

    logic [IW-1:0] cell_id  [0:ENTRIES];
    t_payload      cell_pay [0:ENTRIES];

    assign cell_id[ENTRIES]  = '0;
    assign cell_pay[ENTRIES] = '0;

    jt_ctrl #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_group_key       (i_group_key),
        .i_exit_status_in  (i_exit_status_in),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_ok              (o_ok),
        .o_error_code      (o_error_code),
        .o_job_id          (o_job_id),
        .o_is_done         (o_is_done),
        .o_exit_status_out (o_exit_status_out),
        .o_entry_count     (o_entry_count),
        .o_ctl             (ctl),
        .o_len             (len),
        .o_put_idx         (put_idx),
        .o_put_id          (put_id),
        .o_put_pay         (put_pay),
        .i_head_id         (cell_id[0]),
        .i_head_pay        (cell_pay[0])
    );

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        jt_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_len     (len),
            .i_put_idx (put_idx),
            .i_put_id  (put_id),
            .i_put_pay (put_pay),
            .i_nbr_id  (cell_id[g + 1]),
            .i_nbr_pay (cell_pay[g + 1]),
            .o_id      (cell_id[g]),
            .o_pay     (cell_pay[g])
        );
    end

endmodule
